/* hw/rtl/tpi_pkg.sv */
// tpi_pkg: shared types and constants for the triangle/plane intersection block
// no dependencies; used by tpi_edge and triangle_plane_intersect_top
package tpi_pkg;

	// vertex class against the plane
	typedef enum logic [1:0] {
		CLS_BELOW = 2'd0,
		CLS_ON    = 2'd1,
		CLS_ABOVE = 2'd2
	} cls_t;

	// quotient bits kept for t: covers 1 + tolerance with margin
	function automatic int quo_bits(input int frac);
		return ((frac > 16) ? frac : 16) + 2;
	endfunction

	// register stages of one edge unit: setup, flags, one per quotient bit, range, mult, add
	function automatic int edge_lat(input int frac);
		return quo_bits(frac) + 5;
	endfunction

endpackage

/* hw/rtl/triangle_plane_intersect_top.sv */
// triangle_plane_intersect_top: cuts one triangle per transaction with a horizontal plane
// depends on tpi_pkg and tpi_edge (three instances, one per edge)
//
//  channel      dir  handshake            payload
//  s_*          in   s_tvalid/s_tready    s_tdata: a,b,c vertices xyz and plane height
//  m_*          out  m_tvalid/m_tready    m_tdata: segment points; m_tuser: hit
//  tolerance_*  in   tolerance_we         tolerance_wdata: 16 bit epsilon
//
// one transaction per cycle while m_tready does not stall the output; the one-bit-per-stage
// divider for t on each edge sets the pipeline length
// every stage has its own valid bit and moves when the next stage is empty or moving,
// so bubbles close up under a stall and nothing is lost or repeated
// arst_n clears valid bits and sets tolerance to 1; data registers are not reset
module triangle_plane_intersect_top #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, plane_height, zero pad
	input  logic [((10*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// start_x, start_y, end_x, end_y, zero pad
	output logic [((4*COORD_WIDTH+7)/8)*8-1:0]    m_tdata,
	// hit
	output logic                                  m_tuser,
	input  logic                                  tolerance_we,
	input  logic [15:0]                           tolerance_wdata
);

	localparam int W    = COORD_WIDTH;
	localparam int LAT  = tpi_pkg::edge_lat(FRAC_BITS);
	localparam int NS   = LAT + 2;
	localparam int OW   = ((4*W+7)/8)*8;

	// tolerance register
	logic [15:0] tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 16'd1;
		end else if (tolerance_we) begin
			tol_q <= tolerance_wdata;
		end
	end

	// stage valid bits and advance enables
	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;

	always_comb begin
		en[NS-1] = !vld_q[NS-1] || m_tready;
		for (int i = NS-2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int i = 1; i < NS; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = vld_q[NS-1];

	// input register
	logic signed [W-1:0] vx_s1 [0:2];
	logic signed [W-1:0] vy_s1 [0:2];
	logic signed [W-1:0] vz_s1 [0:2];
	logic signed [W-1:0] pz_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int v = 0; v < 3; v++) begin
				vx_s1[v] <= s_tdata[(3*v)*W +: W];
				vy_s1[v] <= s_tdata[(3*v+1)*W +: W];
				vz_s1[v] <= s_tdata[(3*v+2)*W +: W];
			end
			pz_s1 <= s_tdata[9*W +: W];
		end
	end

	// vertex classification and which edges to try
	tpi_pkg::cls_t       cls_c [0:2];
	logic signed [W+1:0] hi_c, lo_c, vze_c;
	logic [1:0]          nab_c;
	logic                mixed_c;
	logic [2:0]          try_c;

	always_comb begin
		hi_c  = $signed({{2{pz_s1[W-1]}}, pz_s1}) + $signed({{(W-14){1'b0}}, tol_q});
		lo_c  = $signed({{2{pz_s1[W-1]}}, pz_s1}) - $signed({{(W-14){1'b0}}, tol_q});
		nab_c = 2'd0;
		vze_c = '0;
		for (int v = 0; v < 3; v++) begin
			vze_c = $signed({{2{vz_s1[v][W-1]}}, vz_s1[v]});
			if (vze_c > hi_c) begin
				cls_c[v] = tpi_pkg::CLS_ABOVE;
			end else if (vze_c < lo_c) begin
				cls_c[v] = tpi_pkg::CLS_BELOW;
			end else begin
				cls_c[v] = tpi_pkg::CLS_ON;
			end
			nab_c = nab_c + ((cls_c[v] == tpi_pkg::CLS_ABOVE) ? 2'd1 : 2'd0);
		end
		mixed_c  = (nab_c != 2'd0) && (nab_c != 2'd3);
		try_c[0] = mixed_c && (cls_c[0] != cls_c[1]);
		try_c[1] = mixed_c && (cls_c[1] != cls_c[2]);
		try_c[2] = mixed_c && (cls_c[2] != cls_c[0]);
	end

	// edge units a-b, b-c, c-a
	logic                ok_e [0:2];
	logic signed [W-1:0] ex_e [0:2];
	logic signed [W-1:0] ey_e [0:2];

	genvar e;
	generate
		for (e = 0; e < 3; e++) begin : g_edge
			tpi_edge #(
				.W(W),
				.F(FRAC_BITS)
			) u_edge (
				.clk    (clk),
				.en     (en[LAT:1]),
				.tol    (tol_q),
				.try_in (try_c[e]),
				.p1_x   (vx_s1[e]),
				.p1_y   (vy_s1[e]),
				.p1_z   (vz_s1[e]),
				.p2_x   (vx_s1[(e+1)%3]),
				.p2_y   (vy_s1[(e+1)%3]),
				.p2_z   (vz_s1[(e+1)%3]),
				.pz     (pz_s1),
				.ok     (ok_e[e]),
				.ox     (ex_e[e]),
				.oy     (ey_e[e])
			);
		end
	endgenerate

	// pick the first two points found, output register
	logic         hit_c;
	logic [W-1:0] sx_c, sy_c, fx_c, fy_c;
	logic         hit_q;
	logic [W-1:0] sx_q, sy_q, fx_q, fy_q;

	always_comb begin
		hit_c = (ok_e[0] && ok_e[1]) || (ok_e[0] && ok_e[2]) || (ok_e[1] && ok_e[2]);
		sx_c  = ok_e[0] ? ex_e[0] : ex_e[1];
		sy_c  = ok_e[0] ? ey_e[0] : ey_e[1];
		fx_c  = (ok_e[0] && ok_e[1]) ? ex_e[1] : ex_e[2];
		fy_c  = (ok_e[0] && ok_e[1]) ? ey_e[1] : ey_e[2];
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			hit_q <= hit_c;
			sx_q  <= hit_c ? sx_c : '0;
			sy_q  <= hit_c ? sy_c : '0;
			fx_q  <= hit_c ? fx_c : '0;
			fy_q  <= hit_c ? fy_c : '0;
		end
	end

	assign m_tuser = hit_q;
	assign m_tdata = OW'({fy_q, fx_q, sy_q, sx_q});

endmodule

/* hw/rtl/tpi_edge.sv */
// tpi_edge: one triangle edge, pipelined division for t, range test, x/y interpolation
// depends on tpi_pkg
module tpi_edge #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                                  clk,
	input  logic [tpi_pkg::edge_lat(F)-1:0]       en,
	input  logic [15:0]                           tol,
	input  logic                                  try_in,
	input  logic signed [W-1:0]                   p1_x,
	input  logic signed [W-1:0]                   p1_y,
	input  logic signed [W-1:0]                   p1_z,
	input  logic signed [W-1:0]                   p2_x,
	input  logic signed [W-1:0]                   p2_y,
	input  logic signed [W-1:0]                   p2_z,
	input  logic signed [W-1:0]                   pz,
	output logic                                  ok,
	output logic signed [W-1:0]                   ox,
	output logic signed [W-1:0]                   oy
);

	localparam int QB = tpi_pkg::quo_bits(F);
	localparam int SH = QB - F;
	localparam logic [QB-1:0] TONE = {{(QB-F-1){1'b0}}, 1'b1, {F{1'b0}}};

	typedef struct packed {
		logic [W:0]        mdz;
		logic              neg;
		logic              bad;
		logic signed [W:0] dx;
		logic signed [W:0] dy;
		logic [W-1:0]      x1;
		logic [W-1:0]      y1;
	} carry_t;

	// setup stage: differences
	logic signed [W:0] dz_s1, num_s1, dx_s1, dy_s1;
	logic [W-1:0]      x1_s1, y1_s1;
	logic              try_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dz_s1  <= $signed({p2_z[W-1], p2_z}) - $signed({p1_z[W-1], p1_z});
			num_s1 <= $signed({pz[W-1], pz}) - $signed({p1_z[W-1], p1_z});
			dx_s1  <= $signed({p2_x[W-1], p2_x}) - $signed({p1_x[W-1], p1_x});
			dy_s1  <= $signed({p2_y[W-1], p2_y}) - $signed({p1_y[W-1], p1_y});
			x1_s1  <= p1_x;
			y1_s1  <= p1_y;
			try_s1 <= try_in;
		end
	end

	// flag stage: magnitudes, skip and overflow tests, first partial remainder
	logic [W:0]   mdz_c, mnum_c;
	logic         skip_c, ovf_c;
	carry_t       car_c;

	always_comb begin
		mdz_c  = dz_s1[W] ? (W+1)'(-dz_s1) : dz_s1;
		mnum_c = num_s1[W] ? (W+1)'(-num_s1) : num_s1;
		skip_c = !try_s1 || (mdz_c == '0) || (mdz_c < (W+1)'(tol));
		ovf_c  = ({{SH{1'b0}}, mnum_c} >= {mdz_c, {SH{1'b0}}});
		car_c.mdz = mdz_c;
		car_c.neg = num_s1[W] ^ dz_s1[W];
		car_c.bad = skip_c | ovf_c;
		car_c.dx  = dx_s1;
		car_c.dy  = dy_s1;
		car_c.x1  = x1_s1;
		car_c.y1  = y1_s1;
	end

	carry_t          div_car_s [0:QB];
	logic [W:0]      div_rem_s [0:QB];
	logic [QB-1:0]   div_quo_s [0:QB];
	logic [QB-1:0]   div_low_s [0:QB];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			div_car_s[0] <= car_c;
			div_rem_s[0] <= mnum_c >> SH;
			div_quo_s[0] <= '0;
			div_low_s[0] <= {mnum_c[SH-1:0], {F{1'b0}}};
		end
	end

	// restoring division, one quotient bit per stage
	genvar k;
	generate
		for (k = 1; k <= QB; k++) begin : g_div
			logic [W+1:0] r2_c;
			logic         ge_c;
			logic [W+1:0] diff_c;

			always_comb begin
				r2_c   = {div_rem_s[k-1], div_low_s[k-1][QB-1]};
				ge_c   = (r2_c >= {1'b0, div_car_s[k-1].mdz});
				diff_c = r2_c - {1'b0, div_car_s[k-1].mdz};
			end

			always_ff @(posedge clk) begin
				if (en[1+k]) begin
					div_car_s[k] <= div_car_s[k-1];
					div_rem_s[k] <= ge_c ? diff_c[W:0] : r2_c[W:0];
					div_quo_s[k] <= {div_quo_s[k-1][QB-2:0], ge_c};
					div_low_s[k] <= {div_low_s[k-1][QB-2:0], 1'b0};
				end
			end
		end
	endgenerate

	// range stage: t window test and clamp
	logic [QB-1:0] q_c, lim_c;
	logic [F:0]    tc_c;
	logic          inr_c;
	carry_t        cq;

	always_comb begin
		cq    = div_car_s[QB];
		q_c   = div_quo_s[QB];
		lim_c = cq.neg ? QB'(tol) : (TONE + QB'(tol));
		inr_c = (q_c <= lim_c);
		if (cq.neg) begin
			tc_c = '0;
		end else if (q_c > TONE) begin
			tc_c = TONE[F:0];
		end else begin
			tc_c = q_c[F:0];
		end
	end

	logic [F:0]     tc_s1;
	logic           ok_r_s1;
	logic [W:0]     mdx_r_s1, mdy_r_s1;
	logic           sx_r_s1, sy_r_s1;
	logic [W-1:0]   x1_r_s1, y1_r_s1;

	always_ff @(posedge clk) begin
		if (en[QB+2]) begin
			tc_s1    <= tc_c;
			ok_r_s1  <= !cq.bad && inr_c;
			mdx_r_s1 <= cq.dx[W] ? (W+1)'(-cq.dx) : cq.dx;
			mdy_r_s1 <= cq.dy[W] ? (W+1)'(-cq.dy) : cq.dy;
			sx_r_s1  <= cq.dx[W];
			sy_r_s1  <= cq.dy[W];
			x1_r_s1  <= cq.x1;
			y1_r_s1  <= cq.y1;
		end
	end

	// multiply stage: t times edge extent
	logic [W+F+1:0] px_s2, py_s2;
	logic           ok_s2, sx_s2, sy_s2;
	logic [W-1:0]   x1_s2, y1_s2;

	always_ff @(posedge clk) begin
		if (en[QB+3]) begin
			px_s2 <= {{(W+1){1'b0}}, tc_s1} * {{(F+1){1'b0}}, mdx_r_s1};
			py_s2 <= {{(W+1){1'b0}}, tc_s1} * {{(F+1){1'b0}}, mdy_r_s1};
			ok_s2 <= ok_r_s1;
			sx_s2 <= sx_r_s1;
			sy_s2 <= sy_r_s1;
			x1_s2 <= x1_r_s1;
			y1_s2 <= y1_r_s1;
		end
	end

	// add stage: start point plus scaled offset
	always_ff @(posedge clk) begin
		if (en[QB+4]) begin
			ok <= ok_s2;
			ox <= sx_s2 ? (x1_s2 - px_s2[W+F-1:F]) : (x1_s2 + px_s2[W+F-1:F]);
			oy <= sy_s2 ? (y1_s2 - py_s2[W+F-1:F]) : (y1_s2 + py_s2[W+F-1:F]);
		end
	end

endmodule
